// File: hdl/owm_pkg.sv
`timescale 1ns / 1ps
package owm_pkg;

  // command code carried by each tick, same encoding as the action field
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // bus sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_RST_LOW  = 5'b00010,
    PH_RST_REL  = 5'b00100,
    PH_SLOT_LOW = 5'b01000,
    PH_SLOT_REL = 5'b10000
  } phase_t;

  // one classified tick as it travels from front to back
  typedef struct packed {
    op_t        cmd;
    logic [7:0] data;
    logic       line;
  } tick_t;

  localparam int unsigned TC_W = 9;

  // timing in microsecond ticks
  localparam logic [TC_W-1:0] RST_LOW_TICKS = 9'd480;
  localparam logic [TC_W-1:0] RST_SAMPLE_AT = 9'd120;
  localparam logic [TC_W-1:0] RST_REL_TICKS = 9'd480;
  localparam logic [TC_W-1:0] W1_LOW        = 9'd10;
  localparam logic [TC_W-1:0] W1_REL        = 9'd55;
  localparam logic [TC_W-1:0] W0_LOW        = 9'd65;
  localparam logic [TC_W-1:0] W0_REL        = 9'd5;
  localparam logic [TC_W-1:0] RD_LOW        = 9'd3;
  localparam logic [TC_W-1:0] RD_SAMPLE_AT  = 9'd10;
  localparam logic [TC_W-1:0] RD_REL        = 9'd63;

  localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

// File: hdl/owm_front.sv
`timescale 1ns / 1ps
module owm_front
  import owm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_data_byte,
  input  logic       in_line_level,
  output logic       push_valid,
  input  logic       push_ready,
  output tick_t      push_item
);

  logic  valid_r, valid_nxt;
  tick_t item_r;
  tick_t item_nxt;

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  // classify the raw action code into a command
  always_comb begin
    item_nxt.cmd  = op_t'(in_action);
    item_nxt.data = in_data_byte;
    item_nxt.line = in_line_level;
    valid_nxt     = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: hdl/owm_queue.sv
`timescale 1ns / 1ps
module owm_queue
  import owm_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  tick_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output tick_t pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tick_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: hdl/owm_back.sv
`timescale 1ns / 1ps
module owm_back
  import owm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  tick_t      pop_item,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_drive_low,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic       out_presence,
  output logic [7:0] out_read_result,
  output logic       out_rejected
);

  phase_t           phase_r, phase_nxt;
  op_t              op_r, op_nxt;
  logic [TC_W-1:0]  tc_r, tc_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             pres_r, pres_nxt;
  logic [7:0]       rd_val_r, rd_val_nxt;

  logic             ov_r, ov_nxt;
  logic             drive_r, busy_r, done_r, rej_r;
  logic             drive_nxt, busy_nxt, done_nxt, rej_nxt;

  logic             step;
  logic [TC_W-1:0]  low_len, rel_len;

  assign pop_ready = !ov_r || out_ready;
  assign step      = pop_valid && pop_ready;

  assign out_valid       = ov_r;
  assign out_drive_low   = drive_r;
  assign out_busy_res    = busy_r;
  assign out_done_res    = done_r;
  assign out_presence    = pres_r;
  assign out_read_result = rd_val_r;
  assign out_rejected    = rej_r;

  always_comb begin
    phase_nxt  = phase_r;
    op_nxt     = op_r;
    tc_nxt     = tc_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    pres_nxt   = pres_r;
    rd_val_nxt = rd_val_r;
    drive_nxt  = 1'b0;
    busy_nxt   = 1'b0;
    done_nxt   = 1'b0;
    rej_nxt    = 1'b0;
    low_len    = RD_LOW;
    rel_len    = RD_REL;

    // command start, only from idle
    if (phase_r == PH_IDLE) begin
      if (pop_item.cmd == OP_RESET) begin
        phase_nxt = PH_RST_LOW;
        op_nxt    = OP_RESET;
        tc_nxt    = '0;
      end else if (pop_item.cmd == OP_WRITE || pop_item.cmd == OP_READ) begin
        phase_nxt = PH_SLOT_LOW;
        op_nxt    = pop_item.cmd;
        tc_nxt    = '0;
        bit_nxt   = '0;
        shift_nxt = (pop_item.cmd == OP_WRITE) ? pop_item.data : 8'd0;
      end
    end else if (pop_item.cmd != OP_NONE) begin
      rej_nxt = 1'b1;
    end

    if (op_nxt != OP_READ) begin
      low_len = shift_nxt[0] ? W1_LOW : W0_LOW;
      rel_len = shift_nxt[0] ? W1_REL : W0_REL;
    end

    // the tick itself, including the start tick
    case (phase_nxt)
      PH_IDLE: begin
      end
      PH_RST_LOW: begin
        busy_nxt  = 1'b1;
        drive_nxt = 1'b1;
        tc_nxt    = tc_nxt + 1'b1;
        if (tc_nxt >= RST_LOW_TICKS) begin
          phase_nxt = PH_RST_REL;
          tc_nxt    = '0;
        end
      end
      PH_RST_REL: begin
        busy_nxt = 1'b1;
        if (tc_nxt == RST_SAMPLE_AT) begin
          pres_nxt = !pop_item.line;
        end
        tc_nxt = tc_nxt + 1'b1;
        if (tc_nxt >= RST_REL_TICKS) begin
          phase_nxt = PH_IDLE;
          op_nxt    = OP_NONE;
          tc_nxt    = '0;
          done_nxt  = 1'b1;
        end
      end
      PH_SLOT_LOW: begin
        busy_nxt  = 1'b1;
        drive_nxt = 1'b1;
        tc_nxt    = tc_nxt + 1'b1;
        if (tc_nxt >= low_len) begin
          phase_nxt = PH_SLOT_REL;
          tc_nxt    = '0;
        end
      end
      PH_SLOT_REL: begin
        busy_nxt = 1'b1;
        if (op_nxt == OP_READ && tc_nxt == RD_SAMPLE_AT) begin
          shift_nxt = {pop_item.line, shift_nxt[7:1]};
        end
        tc_nxt = tc_nxt + 1'b1;
        if (tc_nxt >= rel_len) begin
          tc_nxt = '0;
          if (op_nxt == OP_WRITE) begin
            shift_nxt = {1'b0, shift_nxt[7:1]};
          end
          if (bit_nxt == LAST_BIT) begin
            if (op_nxt == OP_READ) begin
              rd_val_nxt = shift_nxt;
            end
            bit_nxt   = '0;
            phase_nxt = PH_IDLE;
            op_nxt    = OP_NONE;
            done_nxt  = 1'b1;
          end else begin
            bit_nxt   = bit_nxt + 1'b1;
            phase_nxt = PH_SLOT_LOW;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    ov_nxt = ov_r;
    if (pop_ready) begin
      ov_nxt = pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      op_r     <= OP_NONE;
      tc_r     <= '0;
      bit_r    <= '0;
      shift_r  <= '0;
      pres_r   <= 1'b0;
      rd_val_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (step) begin
        phase_r  <= phase_nxt;
        op_r     <= op_nxt;
        tc_r     <= tc_nxt;
        bit_r    <= bit_nxt;
        shift_r  <= shift_nxt;
        pres_r   <= pres_nxt;
        rd_val_r <= rd_val_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      drive_r <= drive_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      rej_r   <= rej_nxt;
    end
  end

endmodule

// File: hdl/one_wire_bus_master_core.sv
`timescale 1ns / 1ps
// standard-speed 1-wire bus master, one input beat per microsecond tick
//
// input channel: in_valid / in_ready with in_action (0 tick only, 1 reset,
// 2 write byte, 3 read byte), in_data_byte and in_line_level, the bus level
// sampled for that tick. result channel: out_valid / out_ready, exactly one
// result beat per input beat, in order: out_drive_low for the tick, busy and
// done flags, last presence answer, last read byte, and a rejected flag for a
// command that arrived while an operation was still running.
//
// the front stage registers and classifies each beat, a 4-entry queue
// follows, and the back sequencer runs the reset/slot timing and holds the
// result in an output register. a beat passes through the front register,
// the queue and the output register; throughput is one beat per cycle,
// as long as out_ready stays high.
//
// when out_ready is low the output register holds, the sequencer stops,
// the queue fills and in_ready drops only once the queue and front stage
// are full. synchronous active-low reset returns to idle with presence and
// the read byte cleared.
module one_wire_bus_master_core
  import owm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_data_byte,
  input  logic       in_line_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_drive_low,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic       out_presence,
  output logic [7:0] out_read_result,
  output logic       out_rejected
);

  // front to queue
  logic  push_valid, push_ready;
  tick_t push_item;

  // queue to back
  logic  pop_valid, pop_ready;
  tick_t pop_item;

  owm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_data_byte  (in_data_byte),
    .in_line_level (in_line_level),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  owm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // sequencer steps once per popped tick, only when the output slot frees
  owm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_item        (pop_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_drive_low   (out_drive_low),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_presence    (out_presence),
    .out_read_result (out_read_result),
    .out_rejected    (out_rejected)
  );

endmodule
